// ===== rtl/wsmh_pkg.sv =====
// ============================================================================
// wsmh_pkg
// Shared widths, constants and types for the word sequence mix hash.
// ============================================================================
package wsmh_pkg;

  localparam int WORD_W     = 64;
  localparam int HALF_W     = 32;
  localparam int SEED_W     = 31;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE = 1'd1;

  // finalizer and golden-ratio multipliers
  localparam logic [HALF_W-1:0] FMIX32_C1 = 32'h85ebca6b;
  localparam logic [HALF_W-1:0] FMIX32_C2 = 32'hc2b2ae35;
  localparam logic [WORD_W-1:0] FMIX64_C1 = 64'hff51afd7ed558ccd;
  localparam logic [WORD_W-1:0] FMIX64_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [HALF_W-1:0] GOLD32    = 32'h9e3779b9;
  localparam logic [WORD_W-1:0] GOLD64    = 64'h9e3779b97f4a7c15;

  // item class, set by the front end
  typedef logic [1:0] op_t;
  localparam op_t OP_WORD  = 2'd0;  // inner word, no result
  localparam op_t OP_LAST  = 2'd1;  // closing word, gives the hash
  localparam op_t OP_EMPTY = 2'd2;  // zero-word key, gives the seed

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] word;
  } item_t;

endpackage

// ===== rtl/wsmh_front.sv =====
// ============================================================================
// wsmh_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ============================================================================
module wsmh_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [wsmh_pkg::WORD_W-1:0] key_word,
  input  logic                       last_word,
  input  logic                       empty_key,
  output wsmh_pkg::item_t            head,
  output logic                       head_valid,
  input  logic                       head_take
);
  import wsmh_pkg::*;

  item_t      q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;
  item_t      item_in;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];
  assign wr_en      = push && !full;
  assign rd_en      = head_take && head_valid;

  // empty-key flag wins over everything else
  always_comb begin
    item_in.word = key_word;
    if (empty_key) begin
      item_in.op = OP_EMPTY;
    end else if (last_word) begin
      item_in.op = OP_LAST;
    end else begin
      item_in.op = OP_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/wsmh_back.sv =====
// ============================================================================
// wsmh_back
// Hash sequencer: finalizer and running-hash multiply on one shared
// 32x32 multiplier, plus the one-beat result register.
// ============================================================================
module wsmh_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wsmh_pkg::item_t             head,
  input  logic                        head_valid,
  output logic                        head_take,
  input  logic [wsmh_pkg::SEED_W-1:0] seed,
  input  logic                        wide_mode,
  output logic [wsmh_pkg::WORD_W-1:0] key_hash,
  output logic                        empty,
  input  logic                        pop
);
  import wsmh_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_MUL3 = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  function automatic logic [WORD_W-1:0] xs64(input logic [WORD_W-1:0] v);
    xs64 = v ^ (v >> 33);
  endfunction

  function automatic logic [WORD_W-1:0] xs32(input logic [HALF_W-1:0] v,
                                             input logic               by16);
    logic [HALF_W-1:0] r;
    r    = by16 ? (v ^ (v >> 16)) : (v ^ (v >> 13));
    xs32 = {{(WORD_W-HALF_W){1'b0}}, r};
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          mcnt_r;
  logic [WORD_W-1:0]   v_r, h_r, acc_r, prod_r, run_r, out_r;
  logic                key_start_r, last_r, out_valid_r;
  logic                in_mul, mul_done, out_ready, out_load;
  logic [WORD_W-1:0]   mul_x, mul_c, acc_nxt, seed_ext;
  logic [HALF_W-1:0]   mul_a, mul_b;

  assign seed_ext   = {{(WORD_W-SEED_W){1'b0}}, seed};
  assign out_ready  = !out_valid_r || pop;
  assign empty      = !out_valid_r;
  assign key_hash   = out_r;

  // result register loads on an empty key or when a finished hash leaves S_OUT
  assign out_load = (state_r == S_IDLE && head_take && head.op == OP_EMPTY) ||
                    (state_r == S_OUT && out_ready);

  assign in_mul   = (state_r == S_MUL1) || (state_r == S_MUL2) || (state_r == S_MUL3);
  assign mul_done = in_mul && (wide_mode ? (mcnt_r == 2'd3) : (mcnt_r == 2'd1));

  // operand and constant select
  assign mul_x = (state_r == S_MUL3) ? h_r : v_r;
  always_comb begin
    unique case (state_r)
      S_MUL1:  mul_c = wide_mode ? FMIX64_C1 : {{(WORD_W-HALF_W){1'b0}}, FMIX32_C1};
      S_MUL2:  mul_c = wide_mode ? FMIX64_C2 : {{(WORD_W-HALF_W){1'b0}}, FMIX32_C2};
      S_MUL3:  mul_c = wide_mode ? GOLD64    : {{(WORD_W-HALF_W){1'b0}}, GOLD32};
      default: mul_c = '0;
    endcase
  end

  // lo*lo, lo*hi, hi*lo; only the low half of the cross terms survives
  assign mul_a = (mcnt_r == 2'd2) ? mul_x[WORD_W-1:HALF_W] : mul_x[HALF_W-1:0];
  assign mul_b = (mcnt_r == 2'd1) ? mul_c[WORD_W-1:HALF_W] : mul_c[HALF_W-1:0];

  always_comb begin
    if (mcnt_r == 2'd1) begin
      acc_nxt = {wide_mode ? prod_r[WORD_W-1:HALF_W] : {HALF_W{1'b0}},
                 prod_r[HALF_W-1:0]};
    end else begin
      acc_nxt = {acc_r[WORD_W-1:HALF_W] + prod_r[HALF_W-1:0], acc_r[HALF_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (mcnt_r != 2'd0) begin
      acc_r <= acc_nxt;
    end
  end

  // next state
  always_comb begin
    head_take = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head_valid && (head.op != OP_EMPTY || out_ready)) begin
          head_take = 1'b1;
          if (head.op != OP_EMPTY) begin
            state_nxt = S_MUL1;
          end
        end
      end
      S_MUL1: if (mul_done) state_nxt = S_MUL2;
      S_MUL2: if (mul_done) state_nxt = S_MUL3;
      S_MUL3: if (mul_done) state_nxt = last_r ? S_OUT : S_IDLE;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && head_take) begin
      v_r    <= wide_mode ? xs64(head.word) : xs32(head.word[HALF_W-1:0], 1'b1);
      h_r    <= key_start_r ? seed_ext : run_r;
      last_r <= (head.op == OP_LAST);
      if (head.op == OP_EMPTY) begin
        out_r <= seed_ext;
      end
    end
    if (mul_done && state_r == S_MUL1) begin
      v_r <= wide_mode ? xs64(acc_nxt) : xs32(acc_nxt[HALF_W-1:0], 1'b0);
    end
    if (mul_done && state_r == S_MUL2) begin
      v_r <= wide_mode ? xs64(acc_nxt) : xs32(acc_nxt[HALF_W-1:0], 1'b1);
    end
    if (state_r == S_OUT && out_ready) begin
      out_r <= run_r;
    end
  end

  // control and hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mcnt_r      <= 2'd0;
      run_r       <= '0;
      key_start_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_mul) begin
        mcnt_r <= mul_done ? 2'd0 : mcnt_r + 2'd1;
      end
      if (mul_done && state_r == S_MUL3) begin
        run_r       <= acc_nxt ^ v_r;
        key_start_r <= last_r;
      end
      if (state_r == S_IDLE && head_take && head.op == OP_EMPTY) begin
        key_start_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/word_sequence_mix_hash.sv =====
// ============================================================================
// word_sequence_mix_hash
// Multiplicative hash over keys made of 64/32-bit words, each word scrambled
// by the murmur3 finalizer before it is folded into the running hash.
// ============================================================================
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | push / full        | in_key_word, in_last_word, in_empty_key
//  result   | empty / pop        | out_key_hash
//  config   | cfg_valid/cfg_ready| cfg_index (0 seed, 1 wide_mode), cfg_data
//
//  Each word runs three multiplies (two finalizer rounds, then the
//  golden-ratio step) on one shared 32x32 multiplier, after an issue step
//  in S_IDLE. A last word then loads the result register in S_OUT; an empty
//  key loads it straight from S_IDLE. The two-entry front queue keeps taking
//  beats while the back end works or a result waits to be popped.
//  Synchronous active-low reset; no clear pass.
//
module word_sequence_mix_hash (
  input  logic                            clk,
  input  logic                            rst_n,
  // input beats
  input  logic                            push,
  output logic                            full,
  input  logic [wsmh_pkg::WORD_W-1:0]     in_key_word,
  input  logic                            in_last_word,
  input  logic                            in_empty_key,
  // result beats
  output logic                            empty,
  input  logic                            pop,
  output logic [wsmh_pkg::WORD_W-1:0]     out_key_hash,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wsmh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsmh_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wsmh_pkg::*;

  logic [SEED_W-1:0] seed_r;
  logic              wide_mode_r;
  item_t             head;
  logic              head_valid, head_take;

  // registers take a write every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      wide_mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEED:      seed_r      <= cfg_data[SEED_W-1:0];
        REG_WIDE_MODE: wide_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: classify and queue
  wsmh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .key_word   (in_key_word),
    .last_word  (in_last_word),
    .empty_key  (in_empty_key),
    .head       (head),
    .head_valid (head_valid),
    .head_take  (head_take)
  );

  // back: finalizer, running hash, result register
  wsmh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .head_take  (head_take),
    .seed       (seed_r),
    .wide_mode  (wide_mode_r),
    .key_hash   (out_key_hash),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
